FILE: src/sliding_window_rate_limiter_defines.svh
// Assertion macros shared by the limiter modules.
// Depends on nothing; included by files that check their own logic.
`ifndef SLIDING_WINDOW_RATE_LIMITER_DEFINES_SVH
`define SLIDING_WINDOW_RATE_LIMITER_DEFINES_SVH
`ifndef SYNTHESIS
`define SWRL_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("swrl assertion failed");
`define SWRL_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("swrl assertion failed");
`else
`define SWRL_ASSERT(label, clk, rst_n, prop)
`define SWRL_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

FILE: src/swrl_pkg.sv
// Shared constants and types for the sliding window rate limiter.
// Depends on nothing; used by every module of the block.
package swrl_pkg;

    localparam int unsigned RING_DEPTH_DEF = 16;
    localparam int unsigned MAX_REQ_W      = 5;
    localparam int unsigned STAMP_W        = 32;
    localparam int unsigned ADDR_W         = 3;

    localparam logic [MAX_REQ_W-1:0] MAX_REQ_RESET = 5'd4;
    localparam logic [STAMP_W-1:0]   WINDOW_RESET  = 32'd1000;

    localparam logic REG_MAX_REQUESTS  = 1'b0;
    localparam logic REG_WINDOW_LENGTH = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_CHECK = 2'b10
    } state_t;

endpackage

FILE: src/sliding_window_rate_limiter.sv
// Sliding window log rate limiter: config registers, sequencer and stamp ring.
// Depends on swrl_pkg, swrl_ctrl, swrl_ring and swrl_age_cmp.
//
// A request word is taken at a rising edge with start high and busy low; it
// carries the request timestamp. busy stays high while the request is worked.
// The sequencer drops expired stamps from the oldest end, one per cycle,
// through the single age compare unit and the ring read port, then decides.
// The decision appears on granted with done high for exactly one cycle; the
// receiver has no way to hold it off, so it must take it then.
// Order: the accept edge, then one drop per expired stamp, then the decision;
// done rises at the edge that ends the decision. busy falls with done, and
// the next request may be taken in the cycle done is high.
// max_requests (address 0) and window_length (address 4) are written over the
// APB-style port; the user must write them only while busy is low, which
// the block itself does not enforce. Reads return the held values.
// Reset clears the ring to empty and loads max_requests 4, window_length 1000.
module sliding_window_rate_limiter
#(
    parameter int unsigned RING_DEPTH = swrl_pkg::RING_DEPTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [swrl_pkg::STAMP_W-1:0]  timestamp,
    output logic                          done,
    output logic                          granted,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [swrl_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int unsigned PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(RING_DEPTH + 1);

    logic [swrl_pkg::MAX_REQ_W-1:0] max_req_reg;
    logic [swrl_pkg::STAMP_W-1:0]   window_reg;
    logic                           cfg_wr;
    logic                           reg_sel;
    logic [swrl_pkg::STAMP_W-1:0]   rd_data;
    logic [PTR_W-1:0]               rd_addr;
    logic                           wr_en;
    logic [PTR_W-1:0]               wr_addr;
    logic [swrl_pkg::STAMP_W-1:0]   wr_data;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_req_reg <= swrl_pkg::MAX_REQ_RESET;
            window_reg  <= swrl_pkg::WINDOW_RESET;
        end
        else if (cfg_wr)
        begin
            if (reg_sel == swrl_pkg::REG_MAX_REQUESTS)
            begin
                max_req_reg <= pwdata[swrl_pkg::MAX_REQ_W-1:0];
            end
            else
            begin
                window_reg <= pwdata;
            end
        end
    end

    always_comb
    begin
        case (reg_sel)
            swrl_pkg::REG_MAX_REQUESTS:  prdata = 32'(max_req_reg);
            swrl_pkg::REG_WINDOW_LENGTH: prdata = window_reg;
            default:                     prdata = '0;
        endcase
    end

    swrl_ctrl
    #(
        .RING_DEPTH (RING_DEPTH),
        .PTR_W      (PTR_W),
        .CNT_W      (CNT_W)
    )
    u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .timestamp     (timestamp),
        .max_requests  (max_req_reg),
        .window_length (window_reg),
        .rd_data       (rd_data),
        .busy          (busy),
        .done          (done),
        .granted       (granted),
        .rd_addr       (rd_addr),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data)
    );

    swrl_ring
    #(
        .RING_DEPTH (RING_DEPTH),
        .PTR_W      (PTR_W)
    )
    u_ring
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

FILE: src/swrl_age_cmp.sv
// Age compare unit: unsigned stamp difference against the window length.
// Depends on swrl_pkg.
module swrl_age_cmp
(
    input  logic [swrl_pkg::STAMP_W-1:0] now_stamp,
    input  logic [swrl_pkg::STAMP_W-1:0] old_stamp,
    input  logic [swrl_pkg::STAMP_W-1:0] window_length,
    output logic                         expired
);

    logic [swrl_pkg::STAMP_W-1:0] age;

    assign age     = now_stamp - old_stamp;
    assign expired = (age >= window_length);

endmodule

FILE: src/swrl_ring.sv
// Stamp ring memory: one write port, one read port with registered data.
// Depends on swrl_pkg.
module swrl_ring
#(
    parameter int unsigned RING_DEPTH = swrl_pkg::RING_DEPTH_DEF,
    parameter int unsigned PTR_W      = 4
)
(
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [PTR_W-1:0]             wr_addr,
    input  logic [swrl_pkg::STAMP_W-1:0] wr_data,
    input  logic [PTR_W-1:0]             rd_addr,
    output logic [swrl_pkg::STAMP_W-1:0] rd_data
);

    logic [swrl_pkg::STAMP_W-1:0] mem [RING_DEPTH];
    logic [swrl_pkg::STAMP_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/swrl_ctrl.sv
// Sequencer: expires old stamps one per cycle, then grants or refuses.
// Depends on swrl_pkg, swrl_age_cmp and the assertion macro header.
`include "sliding_window_rate_limiter_defines.svh"
module swrl_ctrl
#(
    parameter int unsigned RING_DEPTH = swrl_pkg::RING_DEPTH_DEF,
    parameter int unsigned PTR_W      = 4,
    parameter int unsigned CNT_W      = 5
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [swrl_pkg::STAMP_W-1:0]   timestamp,
    input  logic [swrl_pkg::MAX_REQ_W-1:0] max_requests,
    input  logic [swrl_pkg::STAMP_W-1:0]   window_length,
    input  logic [swrl_pkg::STAMP_W-1:0]   rd_data,
    output logic                           busy,
    output logic                           done,
    output logic                           granted,
    output logic [PTR_W-1:0]               rd_addr,
    output logic                           wr_en,
    output logic [PTR_W-1:0]               wr_addr,
    output logic [swrl_pkg::STAMP_W-1:0]   wr_data
);

    localparam int unsigned LIM_W = (CNT_W > swrl_pkg::MAX_REQ_W) ? CNT_W
                                                                  : swrl_pkg::MAX_REQ_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(RING_DEPTH);

    swrl_pkg::state_t             state_reg, state_next;
    logic [swrl_pkg::STAMP_W-1:0] ts_reg, ts_next;
    logic [PTR_W-1:0]             oldest_reg, oldest_next;
    logic [PTR_W-1:0]             newest_reg, newest_next;
    logic [CNT_W-1:0]             held_reg, held_next;
    logic                         done_reg, done_next;
    logic                         granted_reg, granted_next;
    logic                         expired;
    logic                         pop;
    logic                         can_grant;

    swrl_age_cmp u_age_cmp
    (
        .now_stamp     (ts_reg),
        .old_stamp     (rd_data),
        .window_length (window_length),
        .expired       (expired)
    );

    assign pop       = (held_reg != '0) && expired;
    assign can_grant = (LIM_W'(held_reg) < LIM_W'(max_requests)) && (held_reg != CNT_FULL);

    always_comb
    begin
        state_next   = state_reg;
        ts_next      = ts_reg;
        oldest_next  = oldest_reg;
        newest_next  = newest_reg;
        held_next    = held_reg;
        done_next    = 1'b0;
        granted_next = granted_reg;
        wr_en        = 1'b0;
        case (state_reg)
            swrl_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    ts_next    = timestamp;
                    state_next = swrl_pkg::ST_CHECK;
                end
            end
            swrl_pkg::ST_CHECK:
            begin
                if (pop)
                begin
                    oldest_next = (oldest_reg == PTR_LAST) ? '0 : oldest_reg + 1'b1;
                    held_next   = held_reg - 1'b1;
                end
                else
                begin
                    if (can_grant)
                    begin
                        wr_en       = 1'b1;
                        newest_next = (newest_reg == PTR_LAST) ? '0 : newest_reg + 1'b1;
                        held_next   = held_reg + 1'b1;
                    end
                    done_next    = 1'b1;
                    granted_next = can_grant;
                    state_next   = swrl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = swrl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= swrl_pkg::ST_IDLE;
            oldest_reg  <= '0;
            newest_reg  <= '0;
            held_reg    <= '0;
            done_reg    <= 1'b0;
            granted_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            oldest_reg  <= oldest_next;
            newest_reg  <= newest_next;
            held_reg    <= held_next;
            done_reg    <= done_next;
            granted_reg <= granted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ts_reg <= ts_next;
    end

    assign busy    = (state_reg != swrl_pkg::ST_IDLE);
    assign done    = done_reg;
    assign granted = granted_reg;
    assign rd_addr = oldest_next;
    assign wr_addr = newest_reg;
    assign wr_data = ts_reg;

    `SWRL_ASSERT(a_held_bound, clk, rst_n, held_reg <= CNT_FULL)
    `SWRL_ASSERT(a_done_after_check, clk, rst_n, done_reg |-> $past(state_reg == swrl_pkg::ST_CHECK))
    `SWRL_ASSERT(a_grant_adds_one, clk, rst_n, (done_reg && granted_reg) |-> (held_reg == $past(held_reg) + 1'b1))
    `SWRL_ASSERT(a_pop_drops_one, clk, rst_n, (state_reg == swrl_pkg::ST_CHECK && pop) |=> (held_reg == $past(held_reg) - 1'b1))

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for sliding_window_rate_limiter: directed table, then random phases.
// Depends on swrl_pkg and the limiter RTL; expects grants from row hints or its ring copy.
module tb_top;

    localparam int DEPTH          = swrl_pkg::RING_DEPTH_DEF;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 24;
    localparam int PHASES         = 11;
    localparam int WORDS_PER_PHASE = 64;

    typedef enum logic [1:0] {
        ROW_REQUEST,
        ROW_WRITE
    } row_kind_t;

    typedef enum logic [1:0] {
        GRANT_NO,
        GRANT_YES,
        GRANT_PREDICT
    } grant_hint_t;

    typedef struct packed {
        row_kind_t   kind;
        logic        reg_sel;
        logic [31:0] value;
        grant_hint_t hint;
    } stim_row_t;

    localparam int ROWS = 30;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           start     = 1'b0;
    logic [swrl_pkg::STAMP_W-1:0]   timestamp = '0;
    logic                           psel      = 1'b0;
    logic                           penable   = 1'b0;
    logic                           pwrite    = 1'b0;
    logic [swrl_pkg::ADDR_W-1:0]    paddr     = '0;
    logic [31:0]                    pwdata    = '0;
    logic                           busy;
    logic                           done;
    logic                           granted;
    logic [31:0]                    prdata;
    logic                           pready;

    logic [swrl_pkg::MAX_REQ_W-1:0] cfg_max;
    logic [swrl_pkg::STAMP_W-1:0]   cfg_window;
    logic [swrl_pkg::STAMP_W-1:0]   held_stamps [DEPTH];
    int                             oldest_slot;
    int                             held_total;
    logic                           grant_expect_q [$];
    int                             fault_count = 0;

    stim_row_t directed_rows [ROWS] = '{
        '{ROW_REQUEST, swrl_pkg::REG_MAX_REQUESTS,  32'd0,         GRANT_YES},
        '{ROW_REQUEST, swrl_pkg::REG_MAX_REQUESTS,  32'd10,        GRANT_YES},
        '{ROW_REQUEST, swrl_pkg::REG_MAX_REQUESTS,  32'd20,        GRANT_YES},
        '{ROW_REQUEST, swrl_pkg::REG_MAX_REQUESTS,  32'd30,        GRANT_YES},
        '{ROW_REQUEST, swrl_pkg::REG_MAX_REQUESTS,  32'd40,        GRANT_NO},
        '{ROW_WRITE,   swrl_pkg::REG_MAX_REQUESTS,  32'd0,         GRANT_PREDICT},
        '{ROW_REQUEST, swrl_pkg::REG_MAX_REQUESTS,  32'd50,        GRANT_NO},
        '{ROW_WRITE,   swrl_pkg::REG_MAX_REQUESTS,  32'd31,        GRANT_PREDICT},
        '{ROW_WRITE,   swrl_pkg::REG_WINDOW_LENGTH, 32'hFFFF_FFFF, GRANT_PREDICT},
        '{ROW_REQUEST, swrl_pkg::REG_MAX_REQUESTS,  32'd60,        GRANT_YES},
        '{ROW_REQUEST, swrl_pkg::REG_MAX_REQUESTS,  32'd60,        GRANT_YES},
        '{ROW_REQUEST, swrl_pkg::REG_MAX_REQUESTS,  32'd60,        GRANT_YES},
        '{ROW_REQUEST, swrl_pkg::REG_MAX_REQUESTS,  32'd60,        GRANT_YES},
        '{ROW_REQUEST, swrl_pkg::REG_MAX_REQUESTS,  32'd60,        GRANT_YES},
        '{ROW_REQUEST, swrl_pkg::REG_MAX_REQUESTS,  32'd60,        GRANT_YES},
        '{ROW_REQUEST, swrl_pkg::REG_MAX_REQUESTS,  32'd60,        GRANT_YES},
        '{ROW_REQUEST, swrl_pkg::REG_MAX_REQUESTS,  32'd60,        GRANT_YES},
        '{ROW_REQUEST, swrl_pkg::REG_MAX_REQUESTS,  32'd60,        GRANT_YES},
        '{ROW_REQUEST, swrl_pkg::REG_MAX_REQUESTS,  32'd60,        GRANT_YES},
        '{ROW_REQUEST, swrl_pkg::REG_MAX_REQUESTS,  32'd60,        GRANT_YES},
        '{ROW_REQUEST, swrl_pkg::REG_MAX_REQUESTS,  32'd60,        GRANT_YES},
        '{ROW_REQUEST, swrl_pkg::REG_MAX_REQUESTS,  32'd60,        GRANT_NO},
        '{ROW_WRITE,   swrl_pkg::REG_WINDOW_LENGTH, 32'd0,         GRANT_PREDICT},
        '{ROW_REQUEST, swrl_pkg::REG_MAX_REQUESTS,  32'hFFFF_FFFF, GRANT_YES},
        '{ROW_WRITE,   swrl_pkg::REG_WINDOW_LENGTH, 32'd1000,      GRANT_PREDICT},
        '{ROW_REQUEST, swrl_pkg::REG_MAX_REQUESTS,  32'd0,         GRANT_PREDICT},
        '{ROW_REQUEST, swrl_pkg::REG_MAX_REQUESTS,  32'd999,       GRANT_PREDICT},
        '{ROW_REQUEST, swrl_pkg::REG_MAX_REQUESTS,  32'd1000,      GRANT_PREDICT},
        '{ROW_WRITE,   swrl_pkg::REG_MAX_REQUESTS,  32'd17,        GRANT_PREDICT},
        '{ROW_REQUEST, swrl_pkg::REG_MAX_REQUESTS,  32'd1000,      GRANT_PREDICT}
    };

    sliding_window_rate_limiter DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .timestamp (timestamp),
        .done      (done),
        .granted   (granted),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic logic grant_for_stamp(input logic [swrl_pkg::STAMP_W-1:0] now);
        int                           limit;
        logic [swrl_pkg::STAMP_W-1:0] age;
        logic                         verdict;
        limit   = (cfg_max > DEPTH) ? DEPTH : int'(cfg_max);
        verdict = 1'b0;
        while (held_total != 0)
        begin
            age = now - held_stamps[oldest_slot];
            if (age < cfg_window)
                break;
            oldest_slot = (oldest_slot + 1) % DEPTH;
            held_total--;
        end
        if (held_total < limit)
        begin
            held_stamps[(oldest_slot + held_total) % DEPTH] = now;
            held_total++;
            verdict = 1'b1;
        end
        return verdict;
    endfunction

    task automatic send_request(input logic [swrl_pkg::STAMP_W-1:0] stamp,
                                input grant_hint_t hint);
        logic verdict;
        logic expected;
        start     <= 1'b1;
        timestamp <= stamp;
        do
            @(posedge clk);
        while (busy);
        verdict        = grant_for_stamp(stamp);
        expected       = (hint == GRANT_PREDICT) ? verdict : (hint == GRANT_YES);
        grant_expect_q = {grant_expect_q, expected};
    endtask

    task automatic maybe_pause();
        if ($urandom_range(0, 99) < 31)
        begin
            start     <= 1'b0;
            timestamp <= $urandom;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (grant_expect_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic sel, input logic [31:0] value);
        logic [31:0] held_value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (sel == swrl_pkg::REG_MAX_REQUESTS)
            cfg_max = value[swrl_pkg::MAX_REQ_W-1:0];
        else
            cfg_window = value;
        // read back
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (sel == swrl_pkg::REG_MAX_REQUESTS)
            held_value = {{(32-swrl_pkg::MAX_REQ_W){1'b0}}, cfg_max};
        else
            held_value = cfg_window;
        if ((sel == swrl_pkg::REG_MAX_REQUESTS
             && prdata[swrl_pkg::MAX_REQ_W-1:0] !== cfg_max)
            || (sel == swrl_pkg::REG_WINDOW_LENGTH && prdata !== cfg_window))
        begin
            $display("%0t: register %0d readback mismatch: expected %h, actual %h",
                     $time, sel, held_value, prdata);
            fault_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        logic expected_grant;
        if (rst_n && done)
        begin
            if (grant_expect_q.size() == 0)
            begin
                $display("%0t: unexpected word: expected none, actual granted=%b",
                         $time, granted);
                fault_count++;
            end
            else
            begin
                expected_grant = grant_expect_q.pop_front();
                if (granted !== expected_grant)
                begin
                    $display("%0t: granted mismatch: expected %b, actual %b",
                             $time, expected_grant, granted);
                    fault_count++;
                end
            end
        end
    end

    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (rst_n && ((start && !busy) || done))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        logic [swrl_pkg::STAMP_W-1:0]   now;
        logic [swrl_pkg::MAX_REQ_W-1:0] phase_max;
        logic [swrl_pkg::STAMP_W-1:0]   phase_window;
        longint                         span;
        int                             eff_max;
        bit                             lively;

        cfg_max     = swrl_pkg::MAX_REQ_RESET;
        cfg_window  = swrl_pkg::WINDOW_RESET;
        oldest_slot = 0;
        held_total  = 0;
        foreach (held_stamps[i])
            held_stamps[i] = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_WRITE)
            begin
                drain_results();
                write_register(directed_rows[r].reg_sel, directed_rows[r].value);
            end
            else
            begin
                send_request(directed_rows[r].value, directed_rows[r].hint);
                maybe_pause();
            end
        end

        now = 32'd5000;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain_results();
            case (phase)
                0:       phase_max = 5'd1;
                1:       phase_max = 5'd16;
                2:       phase_max = 5'd17;
                3:       phase_max = 5'd31;
                4:       phase_max = 5'd0;
                default: phase_max = 5'($urandom_range(0, 31));
            endcase
            case ($urandom_range(0, 4))
                0:       phase_window = $urandom_range(0, 3);
                1:       phase_window = $urandom_range(10, 2000);
                2:       phase_window = $urandom;
                3:       phase_window = 32'hFFFF_FFFF;
                default: phase_window = $urandom_range(100, 100000);
            endcase
            write_register(swrl_pkg::REG_MAX_REQUESTS,
                           {{(32-swrl_pkg::MAX_REQ_W){1'b0}}, phase_max});
            write_register(swrl_pkg::REG_WINDOW_LENGTH, phase_window);

            eff_max = (phase_max == 0) ? 1 : ((phase_max > DEPTH) ? DEPTH : int'(phase_max));
            span    = (longint'(phase_window) * 2) / eff_max;
            if (span > 64'hFFFF_FFFF)
                span = 64'hFFFF_FFFF;
            lively = !(phase == 5 || phase == 6);

            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                if ($urandom_range(0, 99) < 5)
                    now = $urandom;
                else if ($urandom_range(0, 99) >= 20)
                    now = now + $urandom_range(0, 32'(span));
                send_request(now, GRANT_PREDICT);
                if (lively)
                    maybe_pause();
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fault_count == 0 && grant_expect_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
